FILE: rtl/snd_pkg.sv
// Shared types, constants and the sigmoid lookup for the sigmoid neuron bank.
// No dependencies; imported by every module of the block.
`default_nettype none

package snd_pkg;

  // Fixed widths of the data fields
  localparam int INPUTS = 4;
  localparam int X_W    = 13;
  localparam int W_W    = 16;
  localparam int O_W    = 13;
  localparam int RATE_W = 16;
  localparam int CFG_W  = 16;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_FWD   = 2'd1;
  localparam logic [1:0] OP_TRAIN = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_TARGET = 1'b0;
  localparam logic CFG_RATE   = 1'b1;

  localparam logic [O_W-1:0]    TARGET_RST = 13'd3686;
  localparam logic [RATE_W-1:0] RATE_RST   = 16'd655;

  localparam logic [O_W-1:0] ONE_Q12 = 13'd4096;
  localparam logic [O_W-1:0] SIG_MAX = 13'd4095;

  // One half at bit 40 of the weight delta product
  localparam logic [56:0] RND40 = 57'h80_0000_0000;

  // One stored neuron: its output and its weights
  typedef struct packed {
    logic [O_W-1:0]             o;
    logic [INPUTS-1:0][W_W-1:0] w;
  } snd_row_t;

  typedef struct packed {
    logic     en;
    snd_row_t row;
  } snd_wr_t;

  // round(4096 * sigmoid(k/2)) for k = 0..16
  function automatic logic [O_W-1:0] sig_lut(input logic [4:0] idx);
    logic [O_W-1:0] v;
    case (idx)
      5'd0:    v = 13'd2048;
      5'd1:    v = 13'd2550;
      5'd2:    v = 13'd2994;
      5'd3:    v = 13'd3349;
      5'd4:    v = 13'd3608;
      5'd5:    v = 13'd3785;
      5'd6:    v = 13'd3902;
      5'd7:    v = 13'd3976;
      5'd8:    v = 13'd4022;
      5'd9:    v = 13'd4051;
      5'd10:   v = 13'd4069;
      5'd11:   v = 13'd4079;
      5'd12:   v = 13'd4086;
      5'd13:   v = 13'd4090;
      5'd14:   v = 13'd4092;
      5'd15:   v = 13'd4094;
      default: v = 13'd4095;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sigmoid_neuron_delta_update_unit.sv
// Bank of NEURONS four-input sigmoid neurons trained by the delta rule.
// Depends on snd_pkg, snd_mul (shared multiplier) and snd_store (neuron rows).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per item: an
//   opcode, a neuron index (taken modulo NEURONS), four Q1.12 inputs and four
//   Q4.12 weights used by load only. Every transaction returns exactly one
//   result on the output channel (out_valid/out_ready): the neuron's stored
//   output and its four weights after the operation.
//   Configuration channel (cfg_valid/cfg_ready, always ready) writes the
//   target output (index 0) or the learning rate (index 1); write it only
//   while no item is in flight.
// Sequence, from the accepting edge to the edge that raises out_valid:
//   load and no-op read the row and finish; forward does four multiplies,
//   then one for the sigmoid interpolation; train does three multiplies for
//   the gradient, then works through each weight in turn: the delta product
//   is split into halves and the sum is saturated back. One item is in work
//   at a time; in_ready returns in the cycle after the result is loaded, so
//   items never overlap. The single shared multiplier runs the multiplies in turn.
// Reset: target 3686 (0.9), rate 655 (0.01), all neuron rows read as zero.
// Stall: a finished result waits in the output register; the sequencer holds
//   in its final state until the register is free, then writes the row back.
`default_nettype none

module sigmoid_neuron_delta_update_unit import snd_pkg::*; #(
  parameter int NEURONS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  // input channel
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [1:0]            in_opcode,
  input  wire logic [2:0]            in_neuron_index,
  input  wire logic [X_W-1:0]        in_x_0,
  input  wire logic [X_W-1:0]        in_x_1,
  input  wire logic [X_W-1:0]        in_x_2,
  input  wire logic [X_W-1:0]        in_x_3,
  input  wire logic signed [W_W-1:0] in_load_w_0,
  input  wire logic signed [W_W-1:0] in_load_w_1,
  input  wire logic signed [W_W-1:0] in_load_w_2,
  input  wire logic signed [W_W-1:0] in_load_w_3,
  // result channel
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [O_W-1:0]        out_neuron_out,
  output      logic signed [W_W-1:0] out_w_out_0,
  output      logic signed [W_W-1:0] out_w_out_1,
  output      logic signed [W_W-1:0] out_w_out_2,
  output      logic signed [W_W-1:0] out_w_out_3
);

  localparam int IDX_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;

  // sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_RD       = 4'd1;
  localparam logic [3:0] ST_FWD_MUL  = 4'd2;
  localparam logic [3:0] ST_FWD_LAST = 4'd3;
  localparam logic [3:0] ST_FWD_SIG  = 4'd4;
  localparam logic [3:0] ST_FWD_FIN  = 4'd5;
  localparam logic [3:0] ST_TR_E     = 4'd6;
  localparam logic [3:0] ST_TR_F     = 4'd7;
  localparam logic [3:0] ST_TR_G     = 4'd8;
  localparam logic [3:0] ST_TR_RG    = 4'd9;
  localparam logic [3:0] ST_TR_A     = 4'd10;
  localparam logic [3:0] ST_TR_HI    = 4'd11;
  localparam logic [3:0] ST_TR_LO    = 4'd12;
  localparam logic [3:0] ST_TR_UPD   = 4'd13;
  localparam logic [3:0] ST_DONE     = 4'd14;

  // Fold the three-bit index into the bank by repeated subtraction.
  function automatic logic [IDX_W-1:0] idx_fold(input logic [2:0] v);
    logic [3:0] t;
    t = {1'b0, v};
    for (int j = 0; j < 8; j++) begin
      if ({28'b0, t} >= NEURONS) begin
        t = t - 4'(NEURONS);
      end
    end
    return IDX_W'(t);
  endfunction

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  logic [3:0]                 state_r, state_nxt;
  logic [1:0]                 k_r;
  logic [1:0]                 op_r;
  logic [IDX_W-1:0]           n_r;
  logic [INPUTS-1:0][X_W-1:0] x_r;
  logic [INPUTS-1:0][W_W-1:0] ld_w_r;
  logic [INPUTS-1:0][W_W-1:0] w_r;
  logic [O_W-1:0]             o_r;
  logic signed [31:0]         acc_r;
  logic                       neg_r;
  logic                       sat_r;
  logic [O_W-1:0]             ybase_r;
  logic signed [24:0]         g_r;
  logic signed [41:0]         a_r;
  logic signed [34:0]         hi_r;
  logic [O_W-1:0]             target_r;
  logic [RATE_W-1:0]          rate_r;
  logic                       out_valid_r;
  logic [O_W-1:0]             out_o_r;
  logic [INPUTS-1:0][W_W-1:0] out_w_r;

  // ---------------------------------------------------------------------
  // Datapath nets
  // ---------------------------------------------------------------------
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  snd_row_t                  rd_row;
  snd_wr_t                   st_wr;
  logic                      in_acc;
  logic                      out_load;

  // sigmoid stage
  logic [31:0]        acc_rnd;
  logic signed [19:0] z_q;
  logic signed [17:0] z_sat;
  logic [17:0]        mag;
  logic [4:0]         sig_i;
  logic [10:0]        sig_f;
  logic [O_W-1:0]     sig_lo;
  logic [O_W-1:0]     sig_d;
  logic [20:0]        frac_sum;
  logic [O_W-1:0]     y_pos;
  logic [O_W-1:0]     y_out;

  // gradient and weight update
  logic signed [13:0]  err;
  logic [13:0]         one_minus_o;
  logic [MUL_P_W-1:0]  g_rnd;
  logic [56:0]         p_full;
  logic [56:0]         p_rnd;
  logic signed [16:0]  delta;
  logic signed [17:0]  w_sum;
  logic [W_W-1:0]      w_sat;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // ---------------------------------------------------------------------
  // Shared multiplier and neuron store
  // ---------------------------------------------------------------------
  snd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign st_wr.en    = out_load;
  assign st_wr.row.o = o_r;
  assign st_wr.row.w = w_r;

  snd_store #(
    .NEURONS (NEURONS),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (idx_fold(in_neuron_index)),
    .rd_row  (rd_row),
    .wr      (st_wr),
    .wr_addr (n_r)
  );

  // ---------------------------------------------------------------------
  // Sigmoid: round the dot product to Q.12, clamp to +-8.0, interpolate
  // ---------------------------------------------------------------------
  always_comb begin
    acc_rnd = acc_r + 32'd2048;
    z_q     = acc_rnd[31:12];
    if (z_q > 20'sd32768) begin
      z_sat = 18'sd32768;
    end else if (z_q < -20'sd32768) begin
      z_sat = -18'sd32768;
    end else begin
      z_sat = z_q[17:0];
    end
    mag    = z_sat[17] ? 18'(-z_sat) : z_sat;
    sig_i  = mag[15:11];
    sig_f  = mag[10:0];
    sig_lo = sig_lut(sig_i);
    sig_d  = sig_lut(sig_i + 5'd1) - sig_lo;
    // finish: add the rounded interpolation term, mirror for negative input
    frac_sum = mul_p[20:0] + 21'd1024;
    y_pos    = sat_r ? SIG_MAX : ybase_r + 13'(frac_sum[20:11]);
    y_out    = neg_r ? ONE_Q12 - y_pos : y_pos;
  end

  // ---------------------------------------------------------------------
  // Gradient and weight update
  // ---------------------------------------------------------------------
  always_comb begin
    err         = {1'b0, target_r} - {1'b0, o_r};
    one_minus_o = {1'b0, ONE_Q12} - {1'b0, o_r};
    g_rnd       = mul_p + 46'd2048;
    // the low half product is non-negative, the high half is signed
    p_full = {hi_r[34], hi_r, 21'b0} + {22'b0, mul_p[34:0]};
    p_rnd  = p_full + RND40;
    delta  = p_rnd[56:40];
    w_sum  = {{2{w_r[k_r][15]}}, w_r[k_r]} + {delta[16], delta};
    if (w_sum > 18'sd32767) begin
      w_sat = 16'h7FFF;
    end else if (w_sum < -18'sd32768) begin
      w_sat = 16'h8000;
    end else begin
      w_sat = w_sum[15:0];
    end
  end

  // ---------------------------------------------------------------------
  // Multiplier operand selection
  // ---------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_FWD_MUL: begin
        mul_a = {15'b0, x_r[k_r]};
        mul_b = {{2{w_r[k_r][15]}}, w_r[k_r]};
      end
      ST_FWD_SIG: begin
        mul_a = {17'b0, sig_f};
        mul_b = {5'b0, sig_d};
      end
      ST_TR_E: begin
        mul_a = {{14{err[13]}}, err};
        mul_b = {5'b0, o_r};
      end
      ST_TR_F: begin
        mul_a = mul_p[27:0];
        mul_b = {4'b0, one_minus_o};
      end
      ST_TR_RG: begin
        mul_a = {{3{g_r[24]}}, g_r};
        mul_b = {2'b0, rate_r};
      end
      ST_TR_HI: begin
        mul_a = {{7{a_r[41]}}, a_r[41:21]};
        mul_b = {5'b0, x_r[k_r]};
      end
      ST_TR_LO: begin
        mul_a = {7'b0, a_r[20:0]};
        mul_b = {5'b0, x_r[k_r]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_RD;
      end
      ST_RD: begin
        case (op_r)
          OP_FWD:   state_nxt = ST_FWD_MUL;
          OP_TRAIN: state_nxt = ST_TR_E;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_FWD_MUL: begin
        if (k_r == 2'd3) state_nxt = ST_FWD_LAST;
      end
      ST_FWD_LAST: state_nxt = ST_FWD_SIG;
      ST_FWD_SIG:  state_nxt = ST_FWD_FIN;
      ST_FWD_FIN:  state_nxt = ST_DONE;
      ST_TR_E:     state_nxt = ST_TR_F;
      ST_TR_F:     state_nxt = ST_TR_G;
      ST_TR_G:     state_nxt = ST_TR_RG;
      ST_TR_RG:    state_nxt = ST_TR_A;
      ST_TR_A:     state_nxt = ST_TR_HI;
      ST_TR_HI:    state_nxt = ST_TR_LO;
      ST_TR_LO:    state_nxt = ST_TR_UPD;
      ST_TR_UPD: begin
        state_nxt = (k_r == 2'd3) ? ST_DONE : ST_TR_HI;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
      target_r    <= TARGET_RST;
      rate_r      <= RATE_RST;
    end else begin
      state_r <= state_nxt;

      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TARGET: target_r <= cfg_data[O_W-1:0];
          CFG_RATE:   rate_r   <= cfg_data[RATE_W-1:0];
          default:    target_r <= target_r;
        endcase
      end

      // step the weight counter through the per-weight loops
      case (state_r)
        ST_RD:      k_r <= 2'd0;
        ST_TR_A:    k_r <= 2'd0;
        ST_FWD_MUL: k_r <= k_r + 2'd1;
        ST_TR_UPD:  k_r <= k_r + 2'd1;
        default:    k_r <= k_r;
      endcase

      // hold the result until taken, drop it on acceptance
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_opcode;
      n_r    <= idx_fold(in_neuron_index);
      x_r    <= {in_x_3, in_x_2, in_x_1, in_x_0};
      ld_w_r <= {in_load_w_3, in_load_w_2, in_load_w_1, in_load_w_0};
    end

    case (state_r)
      ST_RD: begin
        o_r   <= rd_row.o;
        w_r   <= (op_r == OP_LOAD) ? ld_w_r : rd_row.w;
        acc_r <= '0;
      end
      ST_FWD_MUL: begin
        // accumulate the product of the previous multiply from the product register
        if (k_r != 2'd0) acc_r <= acc_r + mul_p[31:0];
      end
      ST_FWD_LAST: acc_r <= acc_r + mul_p[31:0];
      ST_FWD_SIG: begin
        neg_r   <= z_sat[17];
        sat_r   <= mag[16];
        ybase_r <= sig_lo;
      end
      ST_FWD_FIN: o_r <= y_out;
      ST_TR_G:    g_r <= g_rnd[36:12];
      ST_TR_A:    a_r <= mul_p[41:0];
      ST_TR_LO:   hi_r <= mul_p[34:0];
      ST_TR_UPD:  w_r[k_r] <= w_sat;
      default: begin
        acc_r <= acc_r;
      end
    endcase

    if (out_load) begin
      out_o_r <= o_r;
      out_w_r <= w_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_neuron_out = out_o_r;
  assign out_w_out_0    = out_w_r[0];
  assign out_w_out_1    = out_w_r[1];
  assign out_w_out_2    = out_w_r[2];
  assign out_w_out_3    = out_w_r[3];

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // a row write-back always comes with a result in the output register
  a_wb_result: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr.en |=> out_valid)
    else $error("row written back without a result");

  // an accepted transaction starts the row read and blocks new input
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_RD) && !in_ready)
    else $error("sequencer did not start after accept");

  // a forward pass always leaves an output within 0..1.0
  a_fwd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FWD_FIN) |=> (o_r <= ONE_Q12))
    else $error("sigmoid output out of range");

endmodule

`default_nettype wire

FILE: rtl/snd_mul.sv
// Shared signed multiplier with a registered product.
// Depends on snd_pkg for operand widths.
`default_nettype none

module snd_mul import snd_pkg::*; (
  input  wire logic                       clk,
  input  wire logic signed [MUL_A_W-1:0]  a,
  input  wire logic signed [MUL_B_W-1:0]  b,
  output      logic signed [MUL_P_W-1:0]  p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

`default_nettype wire

FILE: rtl/snd_store.sv
// Neuron store: one row per neuron (output and four weights), one write and
// one registered read port, per-row valid bits so unwritten rows read as zero.
// Depends on snd_pkg for the row type.
`default_nettype none

module snd_store import snd_pkg::*; #(
  parameter int NEURONS = 8,
  parameter int IDX_W   = 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output      snd_row_t         rd_row,
  input  wire snd_wr_t          wr,
  input  wire logic [IDX_W-1:0] wr_addr
);

  snd_row_t           mem [NEURONS];
  logic [NEURONS-1:0] valid_r;
  snd_row_t           rd_data_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.row;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  // a row never written reads as zero through its valid bit
  assign rd_row = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

FILE: verif/sigmoid_neuron_delta_update_unit_tb.sv
// Self-checking testbench for the sigmoid neuron bank with delta-rule training.
// Depends on snd_pkg and sigmoid_neuron_delta_update_unit with its snd_mul and snd_store.
// Directed table first, then random load/forward/train sequences over several settings.
`default_nettype none

module sigmoid_neuron_delta_update_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import snd_pkg::*;

  localparam int BANK       = 8;
  localparam int PHASES     = 6;
  localparam int PHASE_ITEMS = 200;
  localparam int SETTLE     = 6;
  localparam int LIMIT      = 800000;

  // Sigmoid samples at half steps, index 0 is the leftmost entry
  localparam logic [0:16][O_W-1:0] SIG_SAMPLES = {
    13'd2048, 13'd2550, 13'd2994, 13'd3349, 13'd3608, 13'd3785, 13'd3902, 13'd3976,
    13'd4022, 13'd4051, 13'd4069, 13'd4079, 13'd4086, 13'd4090, 13'd4092, 13'd4094,
    13'd4095
  };

  typedef logic [0:INPUTS-1][X_W-1:0] xvec_t;
  typedef logic [0:INPUTS-1][W_W-1:0] wvec_t;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] idx;
    xvec_t      x;
    wvec_t      w;
  } item_t;

  typedef struct packed {
    logic [O_W-1:0] o;
    wvec_t          w;
  } result_t;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_opcode;
  logic [2:0]            in_neuron_index;
  logic [X_W-1:0]        in_x_0, in_x_1, in_x_2, in_x_3;
  logic signed [W_W-1:0] in_load_w_0, in_load_w_1, in_load_w_2, in_load_w_3;
  logic                  out_valid;
  logic                  out_ready;
  logic [O_W-1:0]        out_neuron_out;
  logic signed [W_W-1:0] out_w_out_0, out_w_out_1, out_w_out_2, out_w_out_3;

  sigmoid_neuron_delta_update_unit #(.NEURONS(BANK)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_neuron_index (in_neuron_index),
    .in_x_0          (in_x_0),
    .in_x_1          (in_x_1),
    .in_x_2          (in_x_2),
    .in_x_3          (in_x_3),
    .in_load_w_0     (in_load_w_0),
    .in_load_w_1     (in_load_w_1),
    .in_load_w_2     (in_load_w_2),
    .in_load_w_3     (in_load_w_3),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_neuron_out  (out_neuron_out),
    .out_w_out_0     (out_w_out_0),
    .out_w_out_1     (out_w_out_1),
    .out_w_out_2     (out_w_out_2),
    .out_w_out_3     (out_w_out_3)
  );

  // Shadow copy of the neuron bank and the two registers
  logic [W_W-1:0]    shadow_w [BANK][INPUTS];
  logic [O_W-1:0]    shadow_o [BANK];
  logic [O_W-1:0]    target_q12;
  logic [RATE_W-1:0] rate_q16;

  // Results still owed by the block, oldest first
  result_t pending_results [$];
  row_t    directed_rows [$];
  int      fails = 0;
  int      cycles = 0;
  bit      full_speed = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Round half up: floor((v + 2^(sh-1)) / 2^sh)
  function automatic longint round_shift(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // Piecewise-linear sigmoid over |z|, mirrored for negative z
  function automatic logic [O_W-1:0] sigmoid_q12(longint z);
    longint mag, seg, frac, step, y;
    mag = (z < 0) ? -z : z;
    seg = mag >>> 11;
    if (seg >= 16) begin
      y = longint'(SIG_SAMPLES[16]);
    end else begin
      frac = mag & 2047;
      step = longint'(SIG_SAMPLES[seg + 1]) - longint'(SIG_SAMPLES[seg]);
      y = longint'(SIG_SAMPLES[seg]) + ((step * frac + 1024) >>> 11);
    end
    if (z < 0) y = 4096 - y;
    return O_W'(y);
  endfunction

  // Apply one transaction to the shadow bank and return what the block must show
  function automatic result_t neuron_step(item_t it);
    result_t r;
    longint  acc, z, o, grad, delta, nw;
    int      n, k;
    n = int'(it.idx) % BANK;
    case (it.op)
      OP_LOAD: begin
        for (k = 0; k < INPUTS; k++) shadow_w[n][k] = it.w[k];
      end
      OP_FWD: begin
        acc = 0;
        for (k = 0; k < INPUTS; k++)
          acc += longint'(it.x[k]) * longint'($signed(shadow_w[n][k]));
        z = round_shift(acc, 12);
        if (z > 32768) z = 32768;
        if (z < -32768) z = -32768;
        shadow_o[n] = sigmoid_q12(z);
      end
      OP_TRAIN: begin
        o = longint'(shadow_o[n]);
        grad = round_shift((longint'(target_q12) - o) * o * (4096 - o), 12);
        for (k = 0; k < INPUTS; k++) begin
          delta = round_shift(longint'(rate_q16) * grad * longint'(it.x[k]), 40);
          nw = longint'($signed(shadow_w[n][k])) + delta;
          if (nw > 32767) nw = 32767;
          if (nw < -32768) nw = -32768;
          shadow_w[n][k] = W_W'(nw);
        end
      end
      default: ;
    endcase
    r.o = shadow_o[n];
    for (k = 0; k < INPUTS; k++) r.w[k] = shadow_w[n][k];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [X_W-1:0] rand_x();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 13'd4096;
      2: return 13'h1FFF;
      3: return X_W'($urandom_range(4097, 8191));
      default: return X_W'($urandom_range(0, 4096));
    endcase
  endfunction

  function automatic logic [W_W-1:0] rand_w();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3, 4, 5: return W_W'($urandom_range(0, 16383)) - 16'd8192;
      default: return W_W'($urandom());
    endcase
  endfunction

  function automatic item_t make_item(logic [1:0] op, int n);
    item_t it;
    int    k;
    it.op  = op;
    it.idx = 3'(n);
    for (k = 0; k < INPUTS; k++) begin
      it.x[k] = rand_x();
      it.w[k] = rand_w();
    end
    return it;
  endfunction

  task automatic add_row(logic [1:0] op, int n, xvec_t x, wvec_t w,
                         bit typed, logic [O_W-1:0] eo, wvec_t ew);
    row_t r;
    r.it.op  = op;
    r.it.idx = 3'(n);
    r.it.x   = x;
    r.it.w   = w;
    r.typed  = typed;
    r.res.o  = eo;
    r.res.w  = ew;
    directed_rows.push_back(r);
  endtask

  // Enter at a falling edge; leave at a falling edge with valid still high
  // when no gap follows, so back-to-back transactions need no re-raise.
  task automatic send_item(item_t it, bit typed, result_t typed_res);
    result_t predicted;
    int      gap;
    in_opcode       = it.op;
    in_neuron_index = it.idx;
    in_x_0          = it.x[0];
    in_x_1          = it.x[1];
    in_x_2          = it.x[2];
    in_x_3          = it.x[3];
    in_load_w_0     = it.w[0];
    in_load_w_1     = it.w[1];
    in_load_w_2     = it.w[2];
    in_load_w_3     = it.w[3];
    in_valid        = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = neuron_step(it);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
    gap = full_speed ? 0 : idle_len();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_TARGET) target_q12 = data[O_W-1:0];
    else rate_q16 = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold the input side idle until every result is back and the row write-back is done
  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver stalls: runs of ready, broken by stalls of random length
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (full_speed || $urandom_range(0, 2) != 0) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b0;
        repeat (idle_len()) @(negedge clk);
      end
    end
  end

  // Compare every accepted result transaction against the oldest expectation
  always @(posedge clk) begin : check_results
    result_t got, want;
    int      k;
    if (rst_n && out_valid && out_ready) begin
      got.o = out_neuron_out;
      got.w = {out_w_out_0, out_w_out_1, out_w_out_2, out_w_out_3};
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (got.o !== want.o) begin
          $error("neuron_out expected %0d got %0d", want.o, got.o);
          fails++;
        end
        for (k = 0; k < INPUTS; k++) begin
          if (got.w[k] !== want.w[k]) begin
            $error("w_out_%0d expected %0d got %0d", k, $signed(want.w[k]),
                   $signed(got.w[k]));
            fails++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    item_t it;
    int    n, reps, sent, phase, k;
    logic [1:0] op;

    // Drive every input to a known value before the first edge
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_TARGET;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_opcode       = OP_NOP;
    in_neuron_index = '0;
    in_x_0          = '0;
    in_x_1          = '0;
    in_x_2          = '0;
    in_x_3          = '0;
    in_load_w_0     = '0;
    in_load_w_1     = '0;
    in_load_w_2     = '0;
    in_load_w_3     = '0;
    target_q12      = TARGET_RST;
    rate_q16        = RATE_RST;
    for (n = 0; n < BANK; n++) begin
      shadow_o[n] = '0;
      for (k = 0; k < INPUTS; k++) shadow_w[n][k] = '0;
    end

    // Directed table. Typed expectations only where the answer is obvious.
    // No-op right after reset: everything reads zero
    add_row(OP_NOP, 0, '0, '0, 1, 13'd0, '0);
    // Train before any forward: stored output zero, so no weight moves
    add_row(OP_TRAIN, 2, {4{13'd4096}}, '0, 1, 13'd0, '0);
    // Forward with zero weights lands on the sigmoid midpoint
    add_row(OP_FWD, 3, {4{13'd4096}}, '0, 1, 13'd2048, '0);
    // Load the weight extremes; inputs above 1.0 ride along unused
    add_row(OP_LOAD, 1, {4{13'h1FFF}}, {16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF},
            1, 13'd0, {16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF});
    add_row(OP_FWD, 1, {4{13'h1FFF}}, '0, 0, '0, '0);
    add_row(OP_TRAIN, 1, {13'd4096, 13'd0, 13'h1FFF, 13'd1}, '0, 0, '0, '0);
    // Positive saturation of the dot product: top of the table
    add_row(OP_LOAD, 4, '0, {4{16'h7FFF}}, 1, 13'd0, {4{16'h7FFF}});
    add_row(OP_FWD, 4, {4{13'h1FFF}}, '0, 1, 13'd4095, {4{16'h7FFF}});
    add_row(OP_TRAIN, 4, {4{13'h1FFF}}, '0, 0, '0, '0);
    // Negative saturation: mirrored table top
    add_row(OP_LOAD, 5, '0, {4{16'h8000}}, 1, 13'd0, {4{16'h8000}});
    add_row(OP_FWD, 5, {4{13'h1FFF}}, '0, 1, 13'd1, {4{16'h8000}});
    add_row(OP_TRAIN, 5, {4{13'd4096}}, '0, 0, '0, '0);
    add_row(OP_NOP, 5, {4{13'h1FFF}}, {4{16'hFFFF}}, 0, '0, '0);
    // Cancelling products, then an exact table knot at z = 1.0
    add_row(OP_LOAD, 7, '0, {16'h1000, 16'hF000, 16'h0800, 16'h0000},
            1, 13'd0, {16'h1000, 16'hF000, 16'h0800, 16'h0000});
    add_row(OP_FWD, 7, {13'd4096, 13'd4096, 13'd0, 13'd0}, '0, 1, 13'd2048,
            {16'h1000, 16'hF000, 16'h0800, 16'h0000});
    add_row(OP_FWD, 7, {13'd4096, 13'd0, 13'd0, 13'd0}, '0, 1, 13'd2994,
            {16'h1000, 16'hF000, 16'h0800, 16'h0000});
    add_row(OP_TRAIN, 7, {4{13'd4096}}, '0, 0, '0, '0);
    // Tiny weights: rounding of the dot product
    add_row(OP_LOAD, 6, '0, {16'hFFFF, 16'h0001, 16'hFFFE, 16'h0002},
            1, 13'd0, {16'hFFFF, 16'h0001, 16'hFFFE, 16'h0002});
    add_row(OP_FWD, 6, '0, '0, 1, 13'd2048, {16'hFFFF, 16'h0001, 16'hFFFE, 16'h0002});
    add_row(OP_FWD, 6, {4{13'd1}}, '0, 0, '0, '0);
    add_row(OP_FWD, 6, {13'h1FFF, 13'd0, 13'd0, 13'd0}, '0, 0, '0, '0);
    add_row(OP_TRAIN, 6, {4{13'h1FFF}}, '0, 0, '0, '0);
    add_row(OP_NOP, 7, '0, '0, 0, '0, '0);

    // Synchronous reset, released at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table with the reset register values
    foreach (directed_rows[i])
      send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);
    drain();

    // Random phases, each under its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1: begin
          write_reg(CFG_TARGET, 16'd4096);
          write_reg(CFG_RATE, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_TARGET, 16'd0);
          write_reg(CFG_RATE, 16'd0);
        end
        3: begin
          // Bits above the 13-bit target field must be dropped
          write_reg(CFG_TARGET, 16'hFFFF);
          write_reg(CFG_RATE, 16'h8000);
        end
        4: begin
          write_reg(CFG_TARGET, CFG_W'($urandom_range(0, 4096)));
          write_reg(CFG_RATE, CFG_W'($urandom()));
        end
        5: begin
          write_reg(CFG_TARGET, CFG_W'(TARGET_RST));
          write_reg(CFG_RATE, CFG_W'(RATE_RST));
        end
        default: ;
      endcase

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        full_speed = (phase == PHASES - 1) || ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 4) != 0) begin
          // Well-formed sequence: optional load, then forward/train pairs
          n = $urandom_range(0, BANK - 1);
          if ($urandom_range(0, 2) != 0) begin
            send_item(make_item(OP_LOAD, n), 1'b0, '0);
            sent++;
          end
          reps = $urandom_range(1, 6);
          repeat (reps) begin
            send_item(make_item(OP_FWD, n), 1'b0, '0);
            send_item(make_item(OP_TRAIN, n), 1'b0, '0);
            sent += 2;
          end
        end else begin
          // Noise: any opcode on any neuron
          op = 2'($urandom_range(0, 3));
          it = make_item(op, $urandom_range(0, BANK - 1));
          send_item(it, 1'b0, '0);
          if (op != OP_NOP) sent++;
        end
      end
      drain();
    end

    full_speed = 1'b0;
    repeat (20) @(posedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/snd_pkg.sv
rtl/snd_mul.sv
rtl/snd_store.sv
rtl/sigmoid_neuron_delta_update_unit.sv
verif/sigmoid_neuron_delta_update_unit_tb.sv
